// File: src/jtl_pkg.sv
// Shared types, codes and character constants for the JSON token lexer.
package jtl_pkg;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    localparam logic [3:0] TOK_COLON    = 4'd0;
    localparam logic [3:0] TOK_COMMA    = 4'd1;
    localparam logic [3:0] TOK_LBRACE   = 4'd2;
    localparam logic [3:0] TOK_RBRACE   = 4'd3;
    localparam logic [3:0] TOK_LBRACKET = 4'd4;
    localparam logic [3:0] TOK_RBRACKET = 4'd5;
    localparam logic [3:0] TOK_FALSE    = 4'd6;
    localparam logic [3:0] TOK_NULL     = 4'd7;
    localparam logic [3:0] TOK_TRUE     = 4'd8;
    localparam logic [3:0] TOK_NUMBER   = 4'd9;
    localparam logic [3:0] TOK_STRING   = 4'd10;

    localparam logic [2:0] ERR_UNREC   = 3'd0;
    localparam logic [2:0] ERR_KEYWORD = 3'd1;
    localparam logic [2:0] ERR_END     = 3'd2;
    localparam logic [2:0] ERR_DIGIT   = 3'd3;
    localparam logic [2:0] ERR_ZERO    = 3'd4;
    localparam logic [2:0] ERR_UNTERM  = 3'd5;
    localparam logic [2:0] ERR_ESCAPE  = 3'd6;

    localparam logic [1:0] KW_CAND_FALSE = 2'd0;
    localparam logic [1:0] KW_CAND_NULL  = 2'd1;
    localparam logic [1:0] KW_CAND_TRUE  = 2'd2;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_E      = 8'h45;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_UP_Z      = 8'h5A;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LO_A      = 8'h61;
    localparam logic [7:0] CH_LO_B      = 8'h62;
    localparam logic [7:0] CH_LO_E      = 8'h65;
    localparam logic [7:0] CH_LO_F      = 8'h66;
    localparam logic [7:0] CH_LO_N      = 8'h6E;
    localparam logic [7:0] CH_LO_R      = 8'h72;
    localparam logic [7:0] CH_LO_T      = 8'h74;
    localparam logic [7:0] CH_LO_U      = 8'h75;
    localparam logic [7:0] CH_LO_Z      = 8'h7A;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_KEYWORD,
        PH_NUM_SIGN,
        PH_NUM_ZERO,
        PH_NUM_INT,
        PH_NUM_DOT,
        PH_NUM_FRAC,
        PH_NUM_EXP,
        PH_NUM_EXPSIGN,
        PH_NUM_EXPDIG,
        PH_STR,
        PH_STR_ESC,
        PH_STR_HEX
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  token_type;
        logic [7:0]  content_byte;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    // Everything one text byte produces: one or two results
    typedef struct packed {
        logic    dual;
        t_result res0;
        t_result res1;
    } t_packet;

    typedef struct packed {
        t_phase     phase;
        logic       keyword;
        logic [1:0] cand;
        logic       space;
        logic       has_res;
        t_result    res;
    } t_start;

    function automatic t_result mk_content(input logic [3:0] ttype, input logic [7:0] b);
        t_result r;
        r = '0;
        r.kind = KIND_CONTENT;
        r.token_type = ttype;
        r.content_byte = b;
        return r;
    endfunction

    function automatic t_result mk_done(input logic [3:0] ttype, input logic [15:0] len);
        t_result r;
        r = '0;
        r.kind = KIND_DONE;
        r.token_type = ttype;
        r.token_length = len;
        return r;
    endfunction

    function automatic t_result mk_error(input logic [2:0] err);
        t_result r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = err;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= CH_LO_A) && (b <= CH_LO_F))
            || ((b >= CH_UP_A) && (b <= CH_UP_F));
    endfunction

endpackage

// File: src/jtl_front.sv
// Front end: one text byte per cycle when accepted; builds its packet, if any.
module jtl_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_input,
    output logic             o_push,
    output jtl_pkg::t_packet o_packet
);
    import jtl_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_prog, n_prog;
    logic [1:0]             r_cand, n_cand;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [2:0]             r_hex, n_hex;

    logic [LENGTH_BITS-1:0] len_inc;
    logic [1:0]             kw_sel;
    logic [2:0]             kw_len;
    logic [7:0]             kw_chr;
    logic [39:0]            kw_text;
    logic [7:0]             b;
    logic                   eoi;
    t_start                 st;
    t_result                res_a, res_b;
    logic [1:0]             nres;

    function automatic logic [15:0] sat16(input logic [LENGTH_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic t_start start_token(input logic [7:0] c);
        t_start s;
        s = '0;
        s.phase = PH_IDLE;
        if (((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))) begin
            if (c == CH_LO_F || c == CH_LO_N || c == CH_LO_T) begin
                s.keyword = 1'b1;
                s.phase = PH_KEYWORD;
                s.cand = (c == CH_LO_F) ? KW_CAND_FALSE :
                         (c == CH_LO_N) ? KW_CAND_NULL : KW_CAND_TRUE;
            end else begin
                s.has_res = 1'b1;
                s.res = mk_error(ERR_KEYWORD);
            end
        end else if (c == CH_MINUS) begin
            s.has_res = 1'b1;
            s.res = mk_content(TOK_NUMBER, c);
            s.phase = PH_NUM_SIGN;
        end else if (is_digit(c)) begin
            s.has_res = 1'b1;
            s.res = mk_content(TOK_NUMBER, c);
            s.phase = (c == CH_ZERO) ? PH_NUM_ZERO : PH_NUM_INT;
        end else if (c == CH_QUOTE) begin
            s.phase = PH_STR;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            s.space = 1'b1;
        end else begin
            s.has_res = 1'b1;
            case (c)
                CH_COLON:    s.res = mk_done(TOK_COLON, 16'd1);
                CH_COMMA:    s.res = mk_done(TOK_COMMA, 16'd1);
                CH_LBRACE:   s.res = mk_done(TOK_LBRACE, 16'd1);
                CH_RBRACE:   s.res = mk_done(TOK_RBRACE, 16'd1);
                CH_LBRACKET: s.res = mk_done(TOK_LBRACKET, 16'd1);
                CH_RBRACKET: s.res = mk_done(TOK_RBRACKET, 16'd1);
                default:     s.res = mk_error(ERR_UNREC);
            endcase
        end
        return s;
    endfunction

    assign b   = i_text_byte;
    assign eoi = i_end_of_input;
    assign len_inc = (r_len == '1) ? r_len : r_len + 1'b1;

    // keyword spelling lookup
    always_comb begin
        kw_sel = (r_cand > KW_CAND_TRUE) ? KW_CAND_TRUE : r_cand;
        case (kw_sel)
            KW_CAND_FALSE: kw_text = "false";
            KW_CAND_NULL:  kw_text = {"null", 8'h00};
            default:       kw_text = {"true", 8'h00};
        endcase
        kw_len = (kw_sel == KW_CAND_FALSE) ? 3'd5 : 3'd4;
        case (r_prog)
            3'd0:    kw_chr = kw_text[39:32];
            3'd1:    kw_chr = kw_text[31:24];
            3'd2:    kw_chr = kw_text[23:16];
            3'd3:    kw_chr = kw_text[15:8];
            3'd4:    kw_chr = kw_text[7:0];
            default: kw_chr = 8'h00;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_prog  = r_prog;
        n_cand  = r_cand;
        n_len   = r_len;
        n_hex   = r_hex;
        res_a   = '0;
        res_b   = '0;
        nres    = 2'd0;
        st      = start_token(b);
        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!eoi) begin
                        n_phase = st.phase;
                        n_len = st.space ? '0 : LENGTH_BITS'(1);
                        if (st.keyword) begin
                            n_cand = st.cand;
                            n_prog = 3'd1;
                        end
                        if (st.has_res) begin
                            res_a = st.res;
                            nres = 2'd1;
                        end
                    end
                end
                PH_KEYWORD: begin
                    nres = 2'd1;
                    if (eoi || r_prog >= kw_len || b != kw_chr) begin
                        res_a = mk_error(ERR_KEYWORD);
                        n_phase = PH_IDLE;
                    end else begin
                        n_prog = r_prog + 3'd1;
                        n_len = len_inc;
                        if (r_prog + 3'd1 == kw_len) begin
                            res_a = mk_done(TOK_FALSE + 4'(kw_sel), sat16(len_inc));
                            n_phase = PH_IDLE;
                        end else begin
                            nres = 2'd0;
                        end
                    end
                end
                PH_NUM_SIGN, PH_NUM_DOT, PH_NUM_EXPSIGN: begin
                    nres = 2'd1;
                    if (eoi) begin
                        res_a = mk_error(ERR_END);
                        n_phase = PH_IDLE;
                    end else if (!is_digit(b)) begin
                        res_a = mk_error(ERR_DIGIT);
                        n_phase = PH_IDLE;
                    end else begin
                        res_a = mk_content(TOK_NUMBER, b);
                        n_len = len_inc;
                        if (r_phase == PH_NUM_SIGN) begin
                            n_phase = (b == CH_ZERO) ? PH_NUM_ZERO : PH_NUM_INT;
                        end else if (r_phase == PH_NUM_DOT) begin
                            n_phase = PH_NUM_FRAC;
                        end else begin
                            n_phase = PH_NUM_EXPDIG;
                        end
                    end
                end
                PH_NUM_EXP: begin
                    nres = 2'd1;
                    if (eoi) begin
                        res_a = mk_error(ERR_END);
                        n_phase = PH_IDLE;
                    end else if (b == CH_PLUS || b == CH_MINUS) begin
                        res_a = mk_content(TOK_NUMBER, b);
                        n_len = len_inc;
                        n_phase = PH_NUM_EXPSIGN;
                    end else if (is_digit(b)) begin
                        res_a = mk_content(TOK_NUMBER, b);
                        n_len = len_inc;
                        n_phase = PH_NUM_EXPDIG;
                    end else begin
                        res_a = mk_error(ERR_DIGIT);
                        n_phase = PH_IDLE;
                    end
                end
                PH_NUM_ZERO, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPDIG: begin
                    nres = 2'd1;
                    if (eoi) begin
                        res_a = mk_done(TOK_NUMBER, sat16(r_len));
                        n_phase = PH_IDLE;
                    end else if (is_digit(b)) begin
                        if (r_phase == PH_NUM_ZERO) begin
                            res_a = mk_error(ERR_ZERO);
                            n_phase = PH_IDLE;
                        end else begin
                            res_a = mk_content(TOK_NUMBER, b);
                            n_len = len_inc;
                        end
                    end else if (b == CH_DOT
                                 && (r_phase == PH_NUM_ZERO || r_phase == PH_NUM_INT)) begin
                        res_a = mk_content(TOK_NUMBER, b);
                        n_len = len_inc;
                        n_phase = PH_NUM_DOT;
                    end else if ((b == CH_LO_E || b == CH_UP_E) && r_phase != PH_NUM_EXPDIG) begin
                        res_a = mk_content(TOK_NUMBER, b);
                        n_len = len_inc;
                        n_phase = PH_NUM_EXP;
                    end else begin
                        // number ends; this byte starts the next token
                        res_a = mk_done(TOK_NUMBER, sat16(r_len));
                        n_phase = st.phase;
                        n_len = st.space ? '0 : LENGTH_BITS'(1);
                        if (st.keyword) begin
                            n_cand = st.cand;
                            n_prog = 3'd1;
                        end
                        if (st.has_res) begin
                            res_b = st.res;
                            nres = 2'd2;
                        end
                    end
                end
                PH_STR: begin
                    nres = 2'd1;
                    if (eoi || b < CH_SPACE) begin
                        res_a = mk_error(ERR_UNTERM);
                        n_phase = PH_IDLE;
                    end else if (b == CH_QUOTE) begin
                        n_len = len_inc;
                        res_a = mk_done(TOK_STRING, sat16(len_inc));
                        n_phase = PH_IDLE;
                    end else if (b == CH_BACKSLASH) begin
                        n_len = len_inc;
                        n_phase = PH_STR_ESC;
                        nres = 2'd0;
                    end else begin
                        n_len = len_inc;
                        res_a = mk_content(TOK_STRING, b);
                    end
                end
                PH_STR_ESC: begin
                    nres = 2'd1;
                    n_len = len_inc;
                    n_phase = PH_STR;
                    if (eoi) begin
                        res_a = mk_error(ERR_UNTERM);
                        n_len = r_len;
                        n_phase = PH_IDLE;
                    end else begin
                        case (b)
                            CH_LO_B: res_a = mk_content(TOK_STRING, CH_BS);
                            CH_LO_F: res_a = mk_content(TOK_STRING, CH_FF);
                            CH_LO_N: res_a = mk_content(TOK_STRING, CH_LF);
                            CH_LO_R: res_a = mk_content(TOK_STRING, CH_CR);
                            CH_LO_T: res_a = mk_content(TOK_STRING, CH_TAB);
                            CH_QUOTE, CH_BACKSLASH, CH_SLASH:
                                res_a = mk_content(TOK_STRING, b);
                            CH_LO_U: begin
                                nres = 2'd0;
                                n_hex = 3'd4;
                                n_phase = PH_STR_HEX;
                            end
                            default: begin
                                res_a = mk_error(ERR_ESCAPE);
                                n_len = r_len;
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                PH_STR_HEX: begin
                    nres = 2'd1;
                    if (eoi) begin
                        res_a = mk_error(ERR_END);
                        n_phase = PH_IDLE;
                    end else if (!is_hex(b)) begin
                        res_a = mk_error(ERR_DIGIT);
                        n_phase = PH_IDLE;
                    end else if (r_hex > 3'd1) begin
                        nres = 2'd0;
                        n_hex = r_hex - 3'd1;
                        n_len = len_inc;
                    end else begin
                        n_hex = 3'd0;
                        n_len = len_inc;
                        res_a = mk_content(TOK_STRING, CH_QMARK);
                        n_phase = PH_STR;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_prog  = 3'd0;
                    n_cand  = 2'd0;
                    n_len   = '0;
                    n_hex   = 3'd0;
                end
            endcase
        end
        if (nres == 2'd2) begin
            res_b.last = 1'b1;
        end else begin
            res_a.last = 1'b1;
        end
        o_push = i_accept && (nres != 2'd0);
        o_packet.dual = (nres == 2'd2);
        o_packet.res0 = res_a;
        o_packet.res1 = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_prog  <= 3'd0;
            r_cand  <= 2'd0;
            r_len   <= '0;
            r_hex   <= 3'd0;
        end else begin
            r_phase <= n_phase;
            r_prog  <= n_prog;
            r_cand  <= n_cand;
            r_len   <= n_len;
            r_hex   <= n_hex;
        end
    end

endmodule

// File: src/jtl_queue.sv
// Short packet queue between the lexer front end and the result serialiser.
module jtl_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jtl_pkg::t_packet i_packet,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output jtl_pkg::t_packet o_head
);
    import jtl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_packet          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: src/jtl_back.sv
// Result serialiser: holds one packet and hands out its results one transaction at a time.
module jtl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jtl_pkg::t_packet i_head,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output jtl_pkg::t_result o_result
);
    import jtl_pkg::*;

    logic    r_valid;
    logic    r_idx;
    t_packet r_pkt;
    logic    take, load;

    assign take    = i_pop && r_valid;
    // second result of a dual packet goes out before the next packet loads
    assign load    = !r_valid || (take && (r_idx || !r_pkt.dual));
    assign o_q_pop = load && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_result = r_idx ? r_pkt.res1 : r_pkt.res0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            r_idx   <= 1'b0;
        end else if (take) begin
            r_idx   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pkt <= i_head;
        end
    end

endmodule

// File: src/json_token_lexer.sv
// JSON token lexer top level: front end, packet queue and result serialiser.
// Takes one byte of JSON text per cycle (push while full is low) and produces
// zero, one or two results for it: content bytes of numbers and strings, a
// token-complete result with type and source length, or an error. Results
// leave one per cycle (pop while empty is low), so a byte that both ends a
// number and gives a result of its own yields two results. The front end
// never stalls on its own; input backs up only when the QUEUE_DEPTH-entry
// packet queue between the lexer and the serialiser fills, which happens when
// the output side is popped more slowly than results are made. Each result
// is registered in the queue and then in the serialiser. No clearing pass
// after reset; the block takes text from the first cycle after reset.
module json_token_lexer #(
    parameter int LENGTH_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_token_type,
    output logic [7:0]  o_content_byte,
    output logic [15:0] o_token_length,
    output logic [2:0]  o_error_code,
    output logic        o_last
);
    import jtl_pkg::*;

    logic    accept;
    logic    f_push;
    t_packet f_packet;
    logic    q_pop, q_empty;
    t_packet q_head;
    t_result result;

    assign accept = push && !full;

    jtl_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_text_byte    (i_text_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (f_push),
        .o_packet       (f_packet)
    );

    jtl_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_packet (f_packet),
        .i_pop    (q_pop),
        .o_full   (full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    jtl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_result_kind  = result.kind;
    assign o_token_type   = result.token_type;
    assign o_content_byte = result.content_byte;
    assign o_token_length = result.token_length;
    assign o_error_code   = result.error_code;
    assign o_last         = result.last;

endmodule

// File: src/jtl_checker.sv
// Port-level checks for the JSON token lexer, bound to the top level.
module jtl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_result_kind,
    input logic [3:0]  o_token_type,
    input logic [7:0]  o_content_byte,
    input logic [15:0] o_token_length,
    input logic [2:0]  o_error_code,
    input logic        o_last
);
    import jtl_pkg::*;

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not clear after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result_kind) && $stable(o_token_type)
            && $stable(o_content_byte) && $stable(o_token_length)
            && $stable(o_error_code) && $stable(o_last)))
        else $error("waiting result changed before pop");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == KIND_ERROR) |->
            (o_last && o_token_type == TOK_COLON && o_content_byte == 8'h00
             && o_token_length == 16'h0000))
        else $error("error result malformed or not last");

    a_content_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == KIND_CONTENT) |->
            ((o_token_type == TOK_NUMBER || o_token_type == TOK_STRING)
             && o_token_length == 16'h0000 && o_error_code == ERR_UNREC))
        else $error("content result carries wrong fields");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_result_kind  (o_result_kind),
    .o_token_type   (o_token_type),
    .o_content_byte (o_content_byte),
    .o_token_length (o_token_length),
    .o_error_code   (o_error_code),
    .o_last         (o_last)
);
